// ===== sv/vspa_pkg.sv =====
// Shared constants, codes and types of the slot pool allocator.
`timescale 1ns / 1ps

package vspa_pkg;

    // Default pool geometry
    localparam int SLOT_COUNT_DEF = 64;
    localparam int TAG_RANGE_DEF  = 32;

    // Operation codes; any other code acts as a query
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;

    // Result status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_RELINK
    } seq_state_t;

    // Write strobes for the two link memories
    typedef struct packed {
        logic nxt_we;
        logic prv_we;
    } vspa_wr_t;

endpackage

// ===== sv/vspa_ram.sv =====
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps

module vspa_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/vspa_seq.sv =====
// Sequencer: list pointers, allocation counter and read-modify-write of the link memories.
`timescale 1ns / 1ps

module vspa_seq import vspa_pkg::*; #(
    parameter int  SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int  TAG_RANGE  = TAG_RANGE_DEF,
    localparam int SLOT_W     = $clog2(SLOT_COUNT),
    localparam int TAG_W      = $clog2(TAG_RANGE),
    localparam int NXT_W      = TAG_W + SLOT_W,
    localparam int PRV_W      = SLOT_W + 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    // item side
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [SLOT_W-1:0] s_slot_index,
    input  logic [TAG_W-1:0]  s_tag,
    // result side
    input  logic              out_free,
    output logic              res_load,
    output logic [SLOT_W-1:0] res_slot,
    output logic [1:0]        res_status,
    output logic [TAG_W-1:0]  res_tag,
    output logic [SLOT_W-1:0] res_next,
    output logic [SLOT_W-1:0] res_prev,
    output logic [SLOT_W-1:0] res_first,
    // link memories
    output vspa_wr_t          wr,
    output logic [SLOT_W-1:0] nxt_waddr,
    output logic [NXT_W-1:0]  nxt_wdata,
    output logic [SLOT_W-1:0] nxt_raddr,
    input  logic [NXT_W-1:0]  nxt_rdata,
    output logic [SLOT_W-1:0] prv_waddr,
    output logic [PRV_W-1:0]  prv_wdata,
    output logic [SLOT_W-1:0] prv_raddr,
    input  logic [PRV_W-1:0]  prv_rdata
);

    localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);

    seq_state_t state_reg, state_next;

    // List pointers and allocation counter
    logic [SLOT_W-1:0] head_reg, head_next;
    logic [SLOT_W-1:0] tail_reg, tail_next;
    logic [TAG_W-1:0]  tail_tag_reg, tail_tag_next;
    logic [SLOT_W-1:0] free_head_reg, free_head_next;
    logic [SLOT_W-1:0] free_tail_reg, free_tail_next;
    logic [SLOT_W:0]   fresh_cnt_reg, fresh_cnt_next;

    // Item held while it is worked on
    logic [1:0]        op_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [SLOT_W-1:0] id_reg;
    logic              from_free_reg;
    logic              full_reg;
    logic [SLOT_W-1:0] p_reg;
    logic [SLOT_W-1:0] n_reg;
    logic [TAG_W-1:0]  rtag_reg;

    logic              item_take;
    logic              rel_hold;
    logic [SLOT_W-1:0] idx_live;
    logic [SLOT_W-1:0] idx_safe;
    logic              alloc_from_free;
    logic [SLOT_W-1:0] alloc_id;
    logic              alloc_full;
    logic [TAG_W-1:0]  rd_tag;
    logic [SLOT_W-1:0] rd_next_raw;
    logic [SLOT_W-1:0] rd_next;
    logic              rd_used;
    logic [SLOT_W-1:0] rd_prev;
    logic              rd_valid;

    assign item_take = s_valid && s_ready;

    // Read address for the slot; slots never handed out read entry 0
    assign idx_live = (state_reg == S_IDLE) ? s_slot_index : idx_reg;
    assign idx_safe = ({1'b0, idx_live} < fresh_cnt_reg) ? idx_live : '0;

    // Pick the slot for an allocation: oldest released first, then a fresh one
    assign alloc_from_free = (free_head_reg != '0);
    assign alloc_id        = alloc_from_free ? free_head_reg : fresh_cnt_reg[SLOT_W-1:0];
    assign alloc_full      = !alloc_from_free && (fresh_cnt_reg >= SLOT_LIMIT);

    // Decode the words read for the held slot; the tail has no successor
    assign rd_tag      = nxt_rdata[NXT_W-1:SLOT_W];
    assign rd_next_raw = nxt_rdata[SLOT_W-1:0];
    assign rd_next     = (idx_reg == tail_reg) ? '0 : rd_next_raw;
    assign rd_used     = prv_rdata[SLOT_W];
    assign rd_prev     = prv_rdata[SLOT_W-1:0];
    assign rd_valid    = (idx_reg != '0) && ({1'b0, idx_reg} < fresh_cnt_reg) && rd_used;

    // Next state, memory accesses and result
    always_comb begin
        state_next     = state_reg;
        s_ready        = 1'b0;
        res_load       = 1'b0;
        res_slot       = idx_reg;
        res_status     = STAT_OK;
        res_tag        = '0;
        res_next       = '0;
        res_prev       = '0;
        res_first      = head_reg;
        wr             = '0;
        nxt_waddr      = '0;
        nxt_wdata      = '0;
        nxt_raddr      = idx_safe;
        prv_waddr      = '0;
        prv_wdata      = '0;
        prv_raddr      = idx_safe;
        rel_hold       = 1'b0;
        head_next      = head_reg;
        tail_next      = tail_reg;
        tail_tag_next  = tail_tag_reg;
        free_head_next = free_head_reg;
        free_tail_next = free_tail_reg;
        fresh_cnt_next = fresh_cnt_reg;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_opcode == OP_ALLOC) begin
                    nxt_raddr = free_head_reg;
                end
                if (s_valid) begin
                    state_next = S_READ;
                    // Link the new slot behind the tail right away
                    if (s_opcode == OP_ALLOC && !alloc_full) begin
                        if (tail_reg != '0) begin
                            wr.nxt_we = 1'b1;
                            nxt_waddr = tail_reg;
                            nxt_wdata = {tail_tag_reg, alloc_id};
                        end
                        wr.prv_we = 1'b1;
                        prv_waddr = alloc_id;
                        prv_wdata = {1'b1, tail_reg};
                    end
                end
            end

            S_READ: begin
                case (op_reg)
                    OP_ALLOC: begin
                        nxt_raddr = id_reg;
                        if (full_reg) begin
                            res_slot   = '0;
                            res_status = STAT_FULL;
                        end else begin
                            res_slot  = id_reg;
                            res_tag   = tag_reg;
                            res_prev  = tail_reg;
                            res_first = (tail_reg == '0) ? id_reg : head_reg;
                        end
                        if (out_free) begin
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                            if (!full_reg) begin
                                wr.nxt_we = 1'b1;
                                nxt_waddr = id_reg;
                                nxt_wdata = {tag_reg, {SLOT_W{1'b0}}};
                                // Advance the free list or the fresh counter
                                if (from_free_reg) begin
                                    if (free_head_reg == free_tail_reg) begin
                                        free_head_next = '0;
                                        free_tail_next = '0;
                                    end else begin
                                        free_head_next = rd_next_raw;
                                    end
                                end else begin
                                    fresh_cnt_next = fresh_cnt_reg + (SLOT_W + 1)'(1);
                                end
                                if (tail_reg == '0) begin
                                    head_next = id_reg;
                                end
                                tail_next     = id_reg;
                                tail_tag_next = tag_reg;
                            end
                        end
                    end

                    OP_RELEASE: begin
                        if (!rd_valid) begin
                            res_status = STAT_BAD;
                            if (out_free) begin
                                res_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end else begin
                            // Fix the successor's back link, append to free list,
                            // and fetch the predecessor's word
                            rel_hold  = 1'b1;
                            nxt_raddr = rd_prev;
                            if (rd_next != '0) begin
                                wr.prv_we = 1'b1;
                                prv_waddr = rd_next;
                                prv_wdata = {1'b1, rd_prev};
                            end
                            if (free_tail_reg != '0) begin
                                wr.nxt_we = 1'b1;
                                nxt_waddr = free_tail_reg;
                                nxt_wdata = {{TAG_W{1'b0}}, idx_reg};
                            end
                            state_next = S_RELINK;
                        end
                    end

                    default: begin
                        if (rd_valid) begin
                            res_tag  = rd_tag;
                            res_next = rd_next;
                            res_prev = rd_prev;
                        end else begin
                            res_status = STAT_BAD;
                        end
                        if (out_free) begin
                            res_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_RELINK: begin
                nxt_raddr = p_reg;
                res_tag   = rtag_reg;
                res_next  = n_reg;
                res_prev  = p_reg;
                res_first = (p_reg == '0) ? n_reg : head_reg;
                if (out_free) begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                    // Point the predecessor past the slot, keep its tag
                    if (p_reg != '0) begin
                        wr.nxt_we = 1'b1;
                        nxt_waddr = p_reg;
                        nxt_wdata = {rd_tag, n_reg};
                    end
                    // Drop the used mark
                    wr.prv_we = 1'b1;
                    prv_waddr = idx_reg;
                    prv_wdata = '0;
                    if (p_reg == '0) begin
                        head_next = n_reg;
                    end
                    if (n_reg == '0) begin
                        tail_next     = p_reg;
                        tail_tag_next = rd_tag;
                    end
                    if (free_tail_reg == '0) begin
                        free_head_next = idx_reg;
                    end
                    free_tail_next = idx_reg;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            tail_tag_reg  <= '0;
            free_head_reg <= '0;
            free_tail_reg <= '0;
            fresh_cnt_reg <= (SLOT_W + 1)'(1);
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            tail_tag_reg  <= tail_tag_next;
            free_head_reg <= free_head_next;
            free_tail_reg <= free_tail_next;
            fresh_cnt_reg <= fresh_cnt_next;
        end
    end

    // Hold the item and the links of a slot being released
    always_ff @(posedge aclk) begin
        if (item_take) begin
            op_reg        <= s_opcode;
            idx_reg       <= s_slot_index;
            tag_reg       <= s_tag;
            id_reg        <= alloc_id;
            from_free_reg <= alloc_from_free;
            full_reg      <= alloc_full;
        end
        if (rel_hold) begin
            p_reg    <= rd_prev;
            n_reg    <= rd_next;
            rtag_reg <= rd_tag;
        end
    end

endmodule

// ===== sv/voice_slot_pool_allocator_unit.sv =====
// Top level of the slot pool allocator: link memories, sequencer and result register.
//
//  Channel  Direction  Ports                                            Transfer when
//  s_       in         s_opcode, s_slot_index, s_tag                    s_valid && s_ready
//  m_       out        m_result_slot, m_status, m_stored_tag,           m_valid && m_ready
//                      m_next_active, m_prev_active, m_first_active
//
//  Allocate and query pass through the idle and read steps, release adds a relink step: every step is one
//  access to the link memory, whose single read port with registered read data sets the pace.
//  One item is worked on at a time; s_ready is high while the sequencer is idle.
//  Reset clears the list pointers and sets the fresh-slot counter to one; the memories are not
//  cleared, since only slots below the counter are ever read as valid.
//  A finished result waits in its last step while the result register is still full.
`timescale 1ns / 1ps

module voice_slot_pool_allocator_unit import vspa_pkg::*; #(
    parameter int  SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int  TAG_RANGE  = TAG_RANGE_DEF,
    localparam int SLOT_W     = $clog2(SLOT_COUNT),
    localparam int TAG_W      = $clog2(TAG_RANGE)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_opcode,
    input  logic [SLOT_W-1:0] s_slot_index,
    input  logic [TAG_W-1:0]  s_tag,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_result_slot,
    output logic [1:0]        m_status,
    output logic [TAG_W-1:0]  m_stored_tag,
    output logic [SLOT_W-1:0] m_next_active,
    output logic [SLOT_W-1:0] m_prev_active,
    output logic [SLOT_W-1:0] m_first_active
);

    localparam int NXT_W = TAG_W + SLOT_W;
    localparam int PRV_W = SLOT_W + 1;

    vspa_wr_t          wr;
    logic [SLOT_W-1:0] nxt_waddr, nxt_raddr, prv_waddr, prv_raddr;
    logic [NXT_W-1:0]  nxt_wdata, nxt_rdata;
    logic [PRV_W-1:0]  prv_wdata, prv_rdata;

    logic              out_free;
    logic              res_load;
    logic [SLOT_W-1:0] res_slot, res_next, res_prev, res_first;
    logic [1:0]        res_status;
    logic [TAG_W-1:0]  res_tag;

    logic              m_valid_reg;
    logic [SLOT_W-1:0] m_result_slot_reg, m_next_active_reg;
    logic [SLOT_W-1:0] m_prev_active_reg, m_first_active_reg;
    logic [1:0]        m_status_reg;
    logic [TAG_W-1:0]  m_stored_tag_reg;

    // Forward links with the slot tag
    vspa_ram #(
        .WIDTH (NXT_W),
        .DEPTH (SLOT_COUNT)
    ) u_nxt_ram (
        .aclk  (aclk),
        .we    (wr.nxt_we),
        .waddr (nxt_waddr),
        .wdata (nxt_wdata),
        .raddr (nxt_raddr),
        .rdata (nxt_rdata)
    );

    // Back links with the used mark
    vspa_ram #(
        .WIDTH (PRV_W),
        .DEPTH (SLOT_COUNT)
    ) u_prv_ram (
        .aclk  (aclk),
        .we    (wr.prv_we),
        .waddr (prv_waddr),
        .wdata (prv_wdata),
        .raddr (prv_raddr),
        .rdata (prv_rdata)
    );

    vspa_seq #(
        .SLOT_COUNT (SLOT_COUNT),
        .TAG_RANGE  (TAG_RANGE)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_slot_index (s_slot_index),
        .s_tag        (s_tag),
        .out_free     (out_free),
        .res_load     (res_load),
        .res_slot     (res_slot),
        .res_status   (res_status),
        .res_tag      (res_tag),
        .res_next     (res_next),
        .res_prev     (res_prev),
        .res_first    (res_first),
        .wr           (wr),
        .nxt_waddr    (nxt_waddr),
        .nxt_wdata    (nxt_wdata),
        .nxt_raddr    (nxt_raddr),
        .nxt_rdata    (nxt_rdata),
        .prv_waddr    (prv_waddr),
        .prv_wdata    (prv_wdata),
        .prv_raddr    (prv_raddr),
        .prv_rdata    (prv_rdata)
    );

    // Result register frees up when empty or when its transfer completes
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_result_slot_reg  <= res_slot;
            m_status_reg       <= res_status;
            m_stored_tag_reg   <= res_tag;
            m_next_active_reg  <= res_next;
            m_prev_active_reg  <= res_prev;
            m_first_active_reg <= res_first;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_slot  = m_result_slot_reg;
    assign m_status       = m_status_reg;
    assign m_stored_tag   = m_stored_tag_reg;
    assign m_next_active  = m_next_active_reg;
    assign m_prev_active  = m_prev_active_reg;
    assign m_first_active = m_first_active_reg;

`ifndef SYNTHESIS
    // A successful result never names the null slot
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_OK |-> m_result_slot != '0)
        else $error("ok result names the null slot");

    // A full pool reports the null slot and no tag
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_result_slot == '0 && m_stored_tag == '0)
        else $error("pool-full result carries a slot or tag");

    // Only one item is in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    // A new result is loaded only when the result register can take it
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_result_slot) && $stable(m_status))
        else $error("pending result overwritten");
`endif

endmodule
